// ----- rtl/core/eas_pkg.sv -----
// ----------------------------------------------------------------------------
// eas_pkg
// Shared widths, scaling constants and register codes for the energy-aware
// sleep interval block.
// ----------------------------------------------------------------------------
package eas_pkg;

  // Field widths.
  localparam int RAW_W   = 16;
  localparam int MV_W    = 12;
  localparam int LVL_W   = 3;
  localparam int BASE_W  = 16;
  localparam int MULT_W  = 8;
  localparam int TABLE_W = 64;
  localparam int SLEEP_W = 24;
  localparam int CFG_IDX_W = 3;

  // Scaling constants.
  localparam int RAW_SHIFT     = 16;
  localparam int STORAGE_SCALE = 4000;
  localparam int PANEL_NUM     = 295;
  localparam int PANEL_DEN     = 75;
  localparam int PANEL_GCD     = 5;
  localparam int MV_SCALE      = 1000;
  localparam int LEVEL_MAX     = 7;

  // 295/75 reduces to 59/15; floor(p*295/75) equals floor(p*59/15).
  localparam int PANEL_NUM_R = PANEL_NUM / PANEL_GCD;
  localparam int PANEL_DEN_R = PANEL_DEN / PANEL_GCD;

  // Reciprocal of 15 for dividend below 2^22: ceil(2^26 / 15).
  localparam int PANEL_X_W     = 22;
  localparam int RECIP_SHIFT   = 26;
  localparam int RECIP_W       = 23;
  localparam longint PANEL_RECIP_L =
    ((64'd1 << RECIP_SHIFT) + PANEL_DEN_R - 1) / PANEL_DEN_R;
  localparam logic [RECIP_W-1:0] PANEL_RECIP = RECIP_W'(PANEL_RECIP_L);
  localparam int PANEL_Q_W     = 18;

  // Level datapath widths: numerator is 7 * (v - low).
  localparam int LVL_NUM_W = 15;

  // Register reset values.
  localparam logic [MV_W-1:0]    RST_STORAGE_LOW  = 12'd2200;
  localparam logic [MV_W-1:0]    RST_STORAGE_HIGH = 12'd3300;
  localparam logic [MV_W-1:0]    RST_PANEL_LOW    = 12'd500;
  localparam logic [MV_W-1:0]    RST_PANEL_HIGH   = 12'd3000;
  localparam logic [BASE_W-1:0]  RST_SLEEP_BASE   = 16'd60;
  localparam logic [TABLE_W-1:0] RST_MULT_TABLE   = 64'h0101_0101_0101_0101;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STORAGE_LOW  = 3'd0,
    REG_STORAGE_HIGH = 3'd1,
    REG_PANEL_LOW    = 3'd2,
    REG_PANEL_HIGH   = 3'd3,
    REG_SLEEP_BASE   = 3'd4,
    REG_MULT_TABLE   = 3'd5
  } cfg_reg_t;

  // Threshold pair for one level mapper.
  typedef struct packed {
    logic [MV_W-1:0] low;
    logic [MV_W-1:0] high;
  } thresh_t;

  // Load enables for the two level stages.
  typedef struct packed {
    logic cmp_en;
    logic div_en;
  } lvl_en_t;

endpackage

// ----- rtl/core/eas_scale.sv -----
// ----------------------------------------------------------------------------
// eas_scale
// Three-stage conversion of raw converter samples to millivolts.
// ----------------------------------------------------------------------------
module eas_scale (
  input  logic                      clk,
  input  logic [2:0]                stage_en,
  input  logic [eas_pkg::RAW_W-1:0] storage_raw,
  input  logic [eas_pkg::RAW_W-1:0] panel_raw,
  output logic [eas_pkg::MV_W-1:0]  storage_mv,
  output logic [eas_pkg::MV_W-1:0]  panel_mv
);
  import eas_pkg::*;

  localparam int S_PROD_W = RAW_W + 12;
  localparam int R_PROD_W = PANEL_X_W + RECIP_W;
  localparam int M_PROD_W = PANEL_Q_W + 10;

  logic [S_PROD_W-1:0]  s_prod;
  logic [PANEL_X_W-1:0] p_x_nxt;
  logic [R_PROD_W-1:0]  r_prod;
  logic [M_PROD_W-1:0]  m_prod;

  logic [MV_W-1:0]      s1_mv_r, s2_mv_r, s3_mv_r;
  logic [PANEL_X_W-1:0] p1_x_r;
  logic [PANEL_Q_W-1:0] p2_q_r;
  logic [MV_W-1:0]      p3_mv_r;

  // Stage 1: storage scale and panel divider numerator.
  assign s_prod  = S_PROD_W'(storage_raw) * S_PROD_W'(STORAGE_SCALE);
  assign p_x_nxt = PANEL_X_W'(panel_raw) * PANEL_X_W'(PANEL_NUM_R);

  // Stage 2: divide by 15 through the reciprocal.
  assign r_prod = R_PROD_W'(p1_x_r) * R_PROD_W'(PANEL_RECIP);

  // Stage 3: millivolt scale of the quotient.
  assign m_prod = M_PROD_W'(p2_q_r) * M_PROD_W'(MV_SCALE);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_mv_r <= s_prod[RAW_SHIFT +: MV_W];
      p1_x_r  <= p_x_nxt;
    end
    if (stage_en[1]) begin
      s2_mv_r <= s1_mv_r;
      p2_q_r  <= r_prod[RECIP_SHIFT +: PANEL_Q_W];
    end
    if (stage_en[2]) begin
      s3_mv_r <= s2_mv_r;
      p3_mv_r <= m_prod[RAW_SHIFT +: MV_W];
    end
  end

  assign storage_mv = s3_mv_r;
  assign panel_mv   = p3_mv_r;

endmodule

// ----- rtl/core/eas_level.sv -----
// ----------------------------------------------------------------------------
// eas_level
// Two-stage mapping of a millivolt value to a 0..7 level between thresholds.
// ----------------------------------------------------------------------------
module eas_level (
  input  logic                      clk,
  input  eas_pkg::lvl_en_t          en,
  input  logic [eas_pkg::MV_W-1:0]  mv,
  input  eas_pkg::thresh_t          thr,
  output logic [eas_pkg::LVL_W-1:0] level
);
  import eas_pkg::*;

  logic                 under_r, over_r, flat_r;
  logic [LVL_NUM_W-1:0] num_r;
  logic [MV_W-1:0]      den_r;
  logic [LVL_NUM_W-1:0] num_nxt;
  logic [LVL_W-1:0]     quot;
  logic [LVL_W-1:0]     level_nxt;
  logic [LVL_W-1:0]     level_r;

  // Stage A: compare against thresholds and form 7 * (v - low).
  assign num_nxt = LVL_NUM_W'(mv - thr.low) * LVL_NUM_W'(LEVEL_MAX);

  always_ff @(posedge clk) begin
    if (en.cmp_en) begin
      under_r <= (mv < thr.low);
      over_r  <= (mv > thr.high);
      flat_r  <= (thr.high == thr.low);
      num_r   <= num_nxt;
      den_r   <= thr.high - thr.low;
    end
  end

  // Stage B: three-step restoring divide; the quotient never exceeds 7.
  always_comb begin
    logic [LVL_NUM_W-1:0] rem;
    logic [LVL_NUM_W-1:0] dsh;
    rem  = num_r;
    quot = '0;
    for (int b = LVL_W - 1; b >= 0; b--) begin
      dsh = LVL_NUM_W'(den_r) << b;
      if (rem >= dsh) begin
        rem     = rem - dsh;
        quot[b] = 1'b1;
      end
    end
    if (under_r) begin
      level_nxt = '0;
    end else if (over_r) begin
      level_nxt = LVL_W'(LEVEL_MAX);
    end else if (flat_r) begin
      level_nxt = '0;
    end else begin
      level_nxt = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (en.div_en) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

// ----- rtl/core/energy_aware_sleep_interval.sv -----
// ----------------------------------------------------------------------------
// energy_aware_sleep_interval
// Scales storage and panel samples to millivolts, maps both to energy levels
// and picks a sleep interval from a multiplier table.
//
//   Channel   Dir  Handshake             Payload
//   in_       in   in_valid / in_stall   storage_raw, panel_raw
//   out_      out  out_valid / out_stall storage_mv, panel_mv, storage_level,
//                                        charging_level, sleep_time
//   cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Six register stages: scale (3), level compare and divide (2), table select
// and base multiply (1). One request per cycle while the output is not stalled.
// Each stage holds only when it is full and the stage after it holds, so
// bubbles close up and a stalled output still lets upstream stages fill.
// Synchronous reset clears the stage valid bits and loads the configuration
// registers with their defaults; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module energy_aware_sleep_interval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [eas_pkg::RAW_W-1:0]     in_storage_raw,
  input  logic [eas_pkg::RAW_W-1:0]     in_panel_raw,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [eas_pkg::MV_W-1:0]      out_storage_mv,
  output logic [eas_pkg::MV_W-1:0]      out_panel_mv,
  output logic [eas_pkg::LVL_W-1:0]     out_storage_level,
  output logic [eas_pkg::LVL_W-1:0]     out_charging_level,
  output logic [eas_pkg::SLEEP_W-1:0]   out_sleep_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [eas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eas_pkg::TABLE_W-1:0]   cfg_data
);
  import eas_pkg::*;

  localparam int NSTG = 6;

  logic [MV_W-1:0]    stor_low_r, stor_high_r, pan_low_r, pan_high_r;
  logic [BASE_W-1:0]  base_r;
  logic [TABLE_W-1:0] table_r;

  logic [NSTG:1]   vld_r;
  logic [NSTG+1:1] rdy;
  logic [NSTG:1]   vld_nxt;

  logic [MV_W-1:0]  s3_mv, p3_mv;
  logic [MV_W-1:0]  s4_mv_r, p4_mv_r, s5_mv_r, p5_mv_r, s6_mv_r, p6_mv_r;
  logic [LVL_W-1:0] s5_lvl, c5_lvl, s6_lvl_r, c6_lvl_r;
  logic [SLEEP_W-1:0] sleep6_r;

  thresh_t stor_thr, pan_thr;
  lvl_en_t lvl_en;

  logic [LVL_W:0]     idx_sum;
  logic [LVL_W-1:0]   idx;
  logic [MULT_W-1:0]  mult;
  logic [SLEEP_W-1:0] sleep_nxt;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stor_low_r  <= RST_STORAGE_LOW;
      stor_high_r <= RST_STORAGE_HIGH;
      pan_low_r   <= RST_PANEL_LOW;
      pan_high_r  <= RST_PANEL_HIGH;
      base_r      <= RST_SLEEP_BASE;
      table_r     <= RST_MULT_TABLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_STORAGE_LOW:  stor_low_r  <= cfg_data[MV_W-1:0];
        REG_STORAGE_HIGH: stor_high_r <= cfg_data[MV_W-1:0];
        REG_PANEL_LOW:    pan_low_r   <= cfg_data[MV_W-1:0];
        REG_PANEL_HIGH:   pan_high_r  <= cfg_data[MV_W-1:0];
        REG_SLEEP_BASE:   base_r      <= cfg_data[BASE_W-1:0];
        REG_MULT_TABLE:   table_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or the next one moves.
  always_comb begin
    rdy[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[1] = in_valid;
    for (int k = 2; k <= NSTG; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_stall = !rdy[1];

  // Stages 1 to 3: millivolt scaling.
  eas_scale u_scale (
    .clk         (clk),
    .stage_en    (rdy[3:1]),
    .storage_raw (in_storage_raw),
    .panel_raw   (in_panel_raw),
    .storage_mv  (s3_mv),
    .panel_mv    (p3_mv)
  );

  // Stages 4 and 5: level mapping of both voltages.
  assign stor_thr = '{low: stor_low_r, high: stor_high_r};
  assign pan_thr  = '{low: pan_low_r, high: pan_high_r};
  assign lvl_en   = '{cmp_en: rdy[4], div_en: rdy[5]};

  eas_level u_stor_level (
    .clk   (clk),
    .en    (lvl_en),
    .mv    (s3_mv),
    .thr   (stor_thr),
    .level (s5_lvl)
  );

  eas_level u_pan_level (
    .clk   (clk),
    .en    (lvl_en),
    .mv    (p3_mv),
    .thr   (pan_thr),
    .level (c5_lvl)
  );

  // Stage 6: clamped table index and base multiply.
  always_comb begin
    idx_sum   = (LVL_W+1)'(s5_lvl) + (LVL_W+1)'(c5_lvl >> 1);
    idx       = (idx_sum > (LVL_W+1)'(LEVEL_MAX)) ? '0
                : LVL_W'((LVL_W+1)'(LEVEL_MAX) - idx_sum);
    mult      = table_r[idx*MULT_W +: MULT_W];
    sleep_nxt = SLEEP_W'(base_r) * SLEEP_W'(mult);
  end

  // Millivolt values ride alongside the level stages.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_mv_r <= s3_mv;
      p4_mv_r <= p3_mv;
    end
    if (rdy[5]) begin
      s5_mv_r <= s4_mv_r;
      p5_mv_r <= p4_mv_r;
    end
    if (rdy[6]) begin
      s6_mv_r  <= s5_mv_r;
      p6_mv_r  <= p5_mv_r;
      s6_lvl_r <= s5_lvl;
      c6_lvl_r <= c5_lvl;
      sleep6_r <= sleep_nxt;
    end
  end

  assign out_valid          = vld_r[NSTG];
  assign out_storage_mv     = s6_mv_r;
  assign out_panel_mv       = p6_mv_r;
  assign out_storage_level  = s6_lvl_r;
  assign out_charging_level = c6_lvl_r;
  assign out_sleep_time     = sleep6_r;

endmodule

// ----- dv/energy_aware_sleep_interval_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// energy_aware_sleep_interval_test
// Self-checking bench for the sleep interval block. A table of directed
// requests and register writes runs first, covering the sample extremes,
// equal and inverted thresholds, index clamping, wide and spare register
// writes. Random settings phases follow. Each phase mixes free samples with
// samples aimed at the thresholds, and each is scored by a local predictor
// under random idling on both channels.
// ----------------------------------------------------------------------------
module energy_aware_sleep_interval_test;

  // Scaling as the block defines it.
  localparam longint unsigned STORAGE_FS_MV = 4000;
  localparam longint unsigned DIV_NUM       = 295;
  localparam longint unsigned DIV_DEN       = 75;
  localparam longint unsigned MV_PER_V      = 1000;
  localparam int              LEVEL_TOP     = 7;

  // Register indexes the block does not implement.
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int SETTING_PHASES = 8;
  localparam int PHASE_SAMPLES  = 175;
  localparam int PACE_CHUNK     = 25;
  localparam int TAIL_CYCLES    = 16;

  typedef struct packed {
    logic [11:0] storage_mv;
    logic [11:0] panel_mv;
    logic [2:0]  storage_level;
    logic [2:0]  charging_level;
    logic [23:0] sleep_time;
  } sleep_result_t;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum int {SPAN_ORDERED, SPAN_FULL, SPAN_EQUAL, SPAN_INVERTED} span_mode_t;

  typedef struct {
    row_kind_t     kind;
    logic [2:0]    idx;
    logic [63:0]   data;
    logic [15:0]   s_raw;
    logic [15:0]   p_raw;
    bit            pinned;
    sleep_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_storage_raw = '0;
  logic [15:0] in_panel_raw = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_storage_mv;
  logic [11:0] out_panel_mv;
  logic [2:0]  out_storage_level;
  logic [2:0]  out_charging_level;
  logic [23:0] out_sleep_time;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Typed expectation travelling with a directed request.
  bit            pin_use = 1'b0;
  sleep_result_t pin_result = '0;

  // Settings as the block should hold them.
  logic [11:0] cur_storage_low  = 12'd2200;
  logic [11:0] cur_storage_high = 12'd3300;
  logic [11:0] cur_panel_low    = 12'd500;
  logic [11:0] cur_panel_high   = 12'd3000;
  logic [15:0] cur_sleep_base   = 16'd60;
  logic [63:0] cur_mult_table   = 64'h0101_0101_0101_0101;

  sleep_result_t pending_intervals [$];
  plan_row_t     plan [$];

  int unsigned tx_gap_max = 4;
  int unsigned rx_stall_max = 4;
  int unsigned stall_left = 0;
  int unsigned samples_sent = 0;
  int unsigned intervals_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned fail_count = 0;

  energy_aware_sleep_interval i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_storage_raw     (in_storage_raw),
    .in_panel_raw       (in_panel_raw),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_storage_mv     (out_storage_mv),
    .out_panel_mv       (out_panel_mv),
    .out_storage_level  (out_storage_level),
    .out_charging_level (out_charging_level),
    .out_sleep_time     (out_sleep_time),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #2 clk = ~clk;

  // Maps a voltage onto 0..7 between two thresholds.
  function automatic logic [2:0] energy_level(input int unsigned v, low, high);
    if (v < low) return 3'd0;
    if (v > high) return 3'(LEVEL_TOP);
    if (high == low) return 3'd0;
    return 3'((LEVEL_TOP * (v - low)) / (high - low));
  endfunction

  function automatic sleep_result_t predict_sleep(input logic [15:0] s_raw, p_raw);
    sleep_result_t    r;
    longint unsigned  s_mv, p_mv, mult;
    int               idx;
    s_mv = (64'(s_raw) * STORAGE_FS_MV) >> 16;
    p_mv = (((64'(p_raw) * DIV_NUM) / DIV_DEN) * MV_PER_V) >> 16;
    r.storage_mv     = s_mv[11:0];
    r.panel_mv       = p_mv[11:0];
    r.storage_level  = energy_level(r.storage_mv, cur_storage_low, cur_storage_high);
    r.charging_level = energy_level(r.panel_mv, cur_panel_low, cur_panel_high);
    // A full store with strong charging pushes the index below zero.
    idx = LEVEL_TOP - int'(r.storage_level) - int'(r.charging_level >> 1);
    if (idx < 0) idx = 0;
    mult = (cur_mult_table >> (idx * 8)) & 64'hFF;
    r.sleep_time = 24'(64'(cur_sleep_base) * mult);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [23:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic plan_row_t sample_row(input logic [15:0] s_raw, p_raw);
    return '{ROW_SAMPLE, 3'd0, 64'd0, s_raw, p_raw, 1'b0, '0};
  endfunction

  function automatic plan_row_t pinned_row(input logic [15:0] s_raw, p_raw,
                                           input sleep_result_t want);
    return '{ROW_SAMPLE, 3'd0, 64'd0, s_raw, p_raw, 1'b1, want};
  endfunction

  function automatic plan_row_t write_row(input logic [2:0] idx, input logic [63:0] data);
    return '{ROW_WRITE, idx, data, 16'd0, 16'd0, 1'b0, '0};
  endfunction

  // Threshold pair for one settings phase.
  function automatic void pick_span(input span_mode_t mode, output logic [11:0] low, high);
    int unsigned a, b;
    a = $urandom_range(0, 4095);
    b = $urandom_range(0, 4095);
    case (mode)
      SPAN_ORDERED: begin
        low  = 12'((a < b) ? a : b);
        high = 12'((a < b) ? b : a);
      end
      SPAN_FULL: begin
        low  = 12'd0;
        high = 12'hFFF;
      end
      SPAN_EQUAL: begin
        low  = 12'(a);
        high = 12'(a);
      end
      default: begin
        low  = 12'((a < b) ? b : a);
        high = 12'((a < b) ? a : b);
      end
    endcase
  endfunction

  // A voltage close to one of the thresholds, or anywhere in range.
  function automatic int aim_mv(input int low, high);
    int off;
    off = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 2))
      0:       return low + off;
      1:       return high + off;
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [15:0] storage_raw_near(input int mv);
    int r;
    r = (mv * 65536) / int'(STORAGE_FS_MV) + int'($urandom_range(0, 40)) - 20;
    if (r < 0) r = 0;
    else if (r > 65535) r = 65535;
    return 16'(r);
  endfunction

  function automatic logic [15:0] panel_raw_near(input int mv);
    longint r;
    r = (longint'(mv) * 65536 * longint'(DIV_DEN)) / longint'(DIV_NUM * MV_PER_V)
        + longint'($urandom_range(0, 40)) - 20;
    if (r < 0) r = 0;
    else if (r > 65535) r = 65535;
    return 16'(r);
  endfunction

  // Offers one request after a random gap and holds it until taken.
  task automatic send_sample(input logic [15:0] s_raw, p_raw,
                             input bit pin, input sleep_result_t pin_want);
    int unsigned gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_storage_raw <= s_raw;
    in_panel_raw   <= p_raw;
    pin_use        <= pin;
    pin_result     <= pin_want;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering requests and waits for every expected result.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_intervals.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Register writes update the expected settings; wide data is cut to width.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      reg_writes++;
      case (cfg_index)
        eas_pkg::REG_STORAGE_LOW:  cur_storage_low  <= cfg_data[11:0];
        eas_pkg::REG_STORAGE_HIGH: cur_storage_high <= cfg_data[11:0];
        eas_pkg::REG_PANEL_LOW:    cur_panel_low    <= cfg_data[11:0];
        eas_pkg::REG_PANEL_HIGH:   cur_panel_high   <= cfg_data[11:0];
        eas_pkg::REG_SLEEP_BASE:   cur_sleep_base   <= cfg_data[15:0];
        eas_pkg::REG_MULT_TABLE:   cur_mult_table   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Every accepted request queues the result it must produce.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_intervals.push_back(pin_use ? pin_result
                                          : predict_sleep(in_storage_raw, in_panel_raw));
      samples_sent++;
    end
  end

  // Accepted results are scored against the oldest expectation.
  always @(posedge clk) begin : score_results
    sleep_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_intervals.size() == 0) begin
        $error("Result with nothing expected: storage_mv %0d, sleep_time %0d",
               out_storage_mv, out_sleep_time);
        fail_count++;
      end else begin
        want = pending_intervals.pop_front();
        check_field("storage_mv", want.storage_mv, out_storage_mv);
        check_field("panel_mv", want.panel_mv, out_panel_mv);
        check_field("storage_level", want.storage_level, out_storage_level);
        check_field("charging_level", want.charging_level, out_charging_level);
        check_field("sleep_time", want.sleep_time, out_sleep_time);
        intervals_checked++;
      end
    end
  end

  // Receiver holds off for a random number of cycles after each result.
  always @(posedge clk) begin : rx_pace
    int unsigned n;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (rst_n && out_valid && !out_stall) begin
      n = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      stall_left <= n;
      out_stall  <= (n != 0);
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", pending_intervals.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [11:0] s_lo, s_hi, p_lo, p_hi;
    logic [15:0] base_val, s_raw, p_raw;
    logic [63:0] mult_bits, noise;
    span_mode_t  mode;

    // Directed rows: reset settings, then table, wide writes and odd thresholds.
    plan.push_back(pinned_row(16'h0000, 16'h0000, '{12'd0, 12'd0, 3'd0, 3'd0, 24'd60}));
    plan.push_back(pinned_row(16'hFFFF, 16'hFFFF,
                              '{12'd3999, 12'd3933, 3'd7, 3'd7, 24'd60}));
    plan.push_back(sample_row(16'd36045, 16'd8333));
    plan.push_back(sample_row(16'd8000, 16'd0));
    plan.push_back(sample_row(16'hAAAA, 16'h5555));
    plan.push_back(sample_row(16'h5555, 16'hAAAA));
    plan.push_back(write_row(eas_pkg::REG_MULT_TABLE, 64'h0807_0605_0403_0201));
    plan.push_back(pinned_row(16'h0000, 16'h0000, '{12'd0, 12'd0, 3'd0, 3'd0, 24'd480}));
    plan.push_back(pinned_row(16'hFFFF, 16'hFFFF,
                              '{12'd3999, 12'd3933, 3'd7, 3'd7, 24'd60}));
    plan.push_back(sample_row(16'd49152, 16'd33000));
    plan.push_back(write_row(eas_pkg::REG_SLEEP_BASE, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(write_row(eas_pkg::REG_MULT_TABLE, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(pinned_row(16'h0000, 16'h0000,
                              '{12'd0, 12'd0, 3'd0, 3'd0, 24'd16711425}));
    // Equal storage thresholds at 2000 mV, with junk above the field.
    plan.push_back(write_row(eas_pkg::REG_STORAGE_LOW, 64'hDEAD_BEEF_0000_07D0));
    plan.push_back(write_row(eas_pkg::REG_STORAGE_HIGH, 64'h0000_0000_0000_07D0));
    plan.push_back(pinned_row(16'd32768, 16'h0000,
                              '{12'd2000, 12'd0, 3'd0, 3'd0, 24'd16711425}));
    plan.push_back(sample_row(16'd32767, 16'h0000));
    plan.push_back(sample_row(16'd32785, 16'h0000));
    // Inverted panel thresholds: 3000 low, 500 high.
    plan.push_back(write_row(eas_pkg::REG_PANEL_LOW, 64'h1234_5678_9ABC_DBB8));
    plan.push_back(write_row(eas_pkg::REG_PANEL_HIGH, 64'hF0F0_0000_0000_01F4));
    plan.push_back(sample_row(16'h0000, 16'h0000));
    plan.push_back(sample_row(16'h0000, 16'd16000));
    plan.push_back(sample_row(16'h0000, 16'hFFFF));
    // Writes to unused indexes must change nothing.
    plan.push_back(write_row(CFG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(write_row(CFG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(sample_row(16'd1234, 16'd4321));
    plan.push_back(write_row(eas_pkg::REG_SLEEP_BASE, 64'h0));
    plan.push_back(pinned_row(16'hFFFF, 16'h0000, '{12'd3999, 12'd0, 3'd7, 3'd0, 24'd0}));
    plan.push_back(write_row(eas_pkg::REG_STORAGE_LOW, 64'h0));
    plan.push_back(write_row(eas_pkg::REG_STORAGE_HIGH, 64'hFFF));
    plan.push_back(sample_row(16'h0000, 16'h0000));
    plan.push_back(sample_row(16'hFFFF, 16'hFFFF));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].s_raw, plan[i].p_raw, plan[i].pinned, plan[i].want);
      end
    end

    // Random settings phases, each followed by a burst of samples.
    for (int ph = 0; ph < SETTING_PHASES; ph++) begin
      mode = span_mode_t'(ph % 4);
      pick_span(mode, s_lo, s_hi);
      pick_span(mode, p_lo, p_hi);
      base_val  = 16'($urandom);
      mult_bits = {$urandom, $urandom};
      if (mode == SPAN_FULL) begin
        base_val  = (ph < 4) ? 16'hFFFF : 16'h0000;
        mult_bits = (ph < 4) ? 64'hFFFF_FFFF_FFFF_FFFF : mult_bits;
      end
      noise = {$urandom, $urandom};
      write_reg(eas_pkg::REG_STORAGE_LOW, {noise[63:12], s_lo});
      write_reg(eas_pkg::REG_STORAGE_HIGH, {noise[51:0], s_hi});
      write_reg(eas_pkg::REG_PANEL_LOW, {noise[55:4], p_lo});
      write_reg(eas_pkg::REG_PANEL_HIGH, {~noise[63:12], p_hi});
      write_reg(eas_pkg::REG_SLEEP_BASE, {noise[47:0], base_val});
      write_reg(eas_pkg::REG_MULT_TABLE, mult_bits);
      if (ph % 2 == 1) write_reg((ph % 4 == 1) ? CFG_SPARE_LO : CFG_SPARE_HI, noise);

      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        // Idling changes every chunk, including stretches with none at all.
        if (k % PACE_CHUNK == 0) begin
          tx_gap_max   = $urandom_range(0, 1) ? 4 : 0;
          rx_stall_max = $urandom_range(0, 1) ? 4 : 0;
        end
        if ($urandom_range(0, 4) < 2) begin
          s_raw = 16'($urandom);
          p_raw = 16'($urandom);
        end else begin
          s_raw = storage_raw_near(aim_mv(cur_storage_low, cur_storage_high));
          p_raw = panel_raw_near(aim_mv(cur_panel_low, cur_panel_high));
        end
        send_sample(s_raw, p_raw, 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d sample pairs over %0d random settings phases plus directed rows,",
             samples_sent, SETTING_PHASES);
    $display("with %0d register writes and %0d sleep results compared.",
             reg_writes, intervals_checked);
    if (fail_count == 0 && pending_intervals.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/eas_pkg.sv
rtl/core/eas_scale.sv
rtl/core/eas_level.sv
rtl/core/energy_aware_sleep_interval.sv
dv/energy_aware_sleep_interval_test.sv
